### rtl/ushc_pkg.sv
// ushc_pkg: shared types, command codes and mode encodings for the UART sleep
// handshake controller. No dependencies; used by ushc_step and the top level.
package ushc_pkg;

    localparam int TIMER_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 16;
    localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd3333;

    // command codes; code 7 has no meaning
    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_ACTIVITY = 3'd1,
        CMD_SLEEP_ACK = 3'd2,
        CMD_WAKE     = 3'd3,
        CMD_REFUSAL  = 3'd4,
        CMD_ENABLE   = 3'd5,
        CMD_DISABLE  = 3'd6
    } cmd_t;

    // power_mode codes as seen on the result port
    localparam logic [1:0] PM_DISABLED = 2'd0;
    localparam logic [1:0] PM_ASLEEP   = 2'd1;
    localparam logic [1:0] PM_AWAKE    = 2'd2;
    localparam logic [1:0] PM_GOING    = 2'd3;

    // internal one-hot mode
    typedef enum logic [3:0] {
        MODE_DISABLED = 4'b0001,
        MODE_ASLEEP   = 4'b0010,
        MODE_AWAKE    = 4'b0100,
        MODE_GOING    = 4'b1000
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  timer_active;
        logic  clock_off;
    } ushc_flags_t;

    typedef struct packed {
        logic sleep_req;
        logic wake_req;
    } ushc_pulse_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        case (m)
            MODE_DISABLED: code = PM_DISABLED;
            MODE_ASLEEP:   code = PM_ASLEEP;
            MODE_AWAKE:    code = PM_AWAKE;
            MODE_GOING:    code = PM_GOING;
            default:       code = PM_DISABLED;
        endcase
        return code;
    endfunction

endpackage

### rtl/ushc_step.sv
// ushc_step: one-item state update of the sleep handshake controller.
// Purely combinational; depends on ushc_pkg.
module ushc_step
    import ushc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  ushc_flags_t            flags,
    input  logic [TIMER_WIDTH-1:0] ticks_left,
    input  logic [2:0]             command,
    input  logic                   sleep_refused,
    input  logic [CFG_WIDTH-1:0]   timeout_ticks,
    output ushc_flags_t            flags_next,
    output logic [TIMER_WIDTH-1:0] ticks_next,
    output ushc_pulse_t            pulse
);

    logic [TIMER_WIDTH-1:0] reload_val;

    // timeout masked (or widened) to the timer width
    assign reload_val = TIMER_WIDTH'(timeout_ticks);

    always_comb
    begin
        flags_next = flags;
        ticks_next = ticks_left;
        pulse      = '0;
        case (cmd_t'(command))
            CMD_TICK:
            begin
                if (flags.timer_active)
                begin
                    if (ticks_left > TIMER_WIDTH'(1))
                    begin
                        ticks_next = ticks_left - TIMER_WIDTH'(1);
                    end
                    else
                    begin
                        flags_next.timer_active = 1'b0;
                        ticks_next              = '0;
                        if (flags.mode == MODE_AWAKE)
                        begin
                            pulse.sleep_req = 1'b1;
                            if (!sleep_refused)
                            begin
                                flags_next.mode = MODE_GOING;
                            end
                        end
                    end
                end
            end
            CMD_ACTIVITY:
            begin
                if (flags.mode != MODE_DISABLED)
                begin
                    flags_next.timer_active = 1'b1;
                    ticks_next              = reload_val;
                end
            end
            CMD_SLEEP_ACK:
            begin
                if (flags.mode == MODE_GOING)
                begin
                    flags_next.mode      = MODE_ASLEEP;
                    flags_next.clock_off = 1'b1;
                end
            end
            CMD_WAKE:
            begin
                if (flags.mode == MODE_ASLEEP || flags.mode == MODE_GOING)
                begin
                    flags_next.mode         = MODE_AWAKE;
                    flags_next.clock_off    = 1'b0;
                    flags_next.timer_active = 1'b1;
                    ticks_next              = reload_val;
                    pulse.wake_req          = 1'b1;
                end
            end
            CMD_REFUSAL:
            begin
                if (flags.mode == MODE_GOING)
                begin
                    flags_next.mode         = MODE_AWAKE;
                    flags_next.clock_off    = 1'b0;
                    flags_next.timer_active = 1'b1;
                    ticks_next              = reload_val;
                    pulse.wake_req          = 1'b1;
                end
            end
            CMD_ENABLE:
            begin
                flags_next.mode = MODE_AWAKE;
            end
            CMD_DISABLE:
            begin
                flags_next.mode         = MODE_DISABLED;
                flags_next.timer_active = 1'b0;
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

endmodule

### rtl/uart_sleep_handshake_controller.sv
// uart_sleep_handshake_controller: top level of the serial-link sleep controller.
// Depends on ushc_pkg and ushc_step.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------
//  in      | in        | in_valid / in_stall     | command, sleep_refused
//  out     | out       | out_valid / out_stall   | power_mode, clock_released,
//          |           |                         | sleep_request, wake_request_out,
//          |           |                         | timer_running
//  cfg     | in        | cfg_valid / cfg_ready   | cfg_data (timeout_ticks)
//
// The state update is one pass of ushc_step between the state registers and the
// result register, so a beat is taken every cycle unless in_stall is high.
// The result appears in the cycle after acceptance and holds while out_stall.
// in_stall rises only while a result sits in the output register and is stalled.
// Reset (rst_n low, asynchronous) gives mode disabled, timer stopped, clock
// locked, timeout 3333. cfg_ready is always high.
module uart_sleep_handshake_controller
    import ushc_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // input beats
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           command,
    input  logic                 sleep_refused,
    // result beats
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           power_mode,
    output logic                 clock_released,
    output logic                 sleep_request,
    output logic                 wake_request_out,
    output logic                 timer_running,
    // timeout register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data
);

    logic [CFG_WIDTH-1:0]   timeout_reg;
    ushc_flags_t            flags_reg;
    ushc_flags_t            flags_next;
    logic [TIMER_WIDTH-1:0] ticks_reg;
    logic [TIMER_WIDTH-1:0] ticks_next;
    ushc_pulse_t            pulse;
    logic                   out_valid_reg;
    logic [1:0]             power_mode_reg;
    logic                   clock_released_reg;
    logic                   sleep_request_reg;
    logic                   wake_request_reg;
    logic                   timer_running_reg;
    logic                   in_accept;

    assign cfg_ready = 1'b1;

    // stall only when the result register is full and cannot drain
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    ushc_step #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_step (
        .flags        (flags_reg),
        .ticks_left   (ticks_reg),
        .command      (command),
        .sleep_refused(sleep_refused),
        .timeout_ticks(timeout_reg),
        .flags_next   (flags_next),
        .ticks_next   (ticks_next),
        .pulse        (pulse)
    );

    // controller state, updated once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg.mode         <= MODE_DISABLED;
            flags_reg.timer_active <= 1'b0;
            flags_reg.clock_off    <= 1'b0;
            ticks_reg              <= '0;
        end
        else if (in_accept)
        begin
            flags_reg <= flags_next;
            ticks_reg <= ticks_next;
        end
    end

    // result register: valid is control, payload is not reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            power_mode_reg     <= mode_code(flags_next.mode);
            clock_released_reg <= flags_next.clock_off;
            sleep_request_reg  <= pulse.sleep_req;
            wake_request_reg   <= pulse.wake_req;
            timer_running_reg  <= flags_next.timer_active;
        end
    end

    assign out_valid        = out_valid_reg;
    assign power_mode       = power_mode_reg;
    assign clock_released   = clock_released_reg;
    assign sleep_request    = sleep_request_reg;
    assign wake_request_out = wake_request_reg;
    assign timer_running    = timer_running_reg;

    // the two request pulses come from different commands
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(sleep_request && wake_request_out))
        else $error("sleep and wake requests in the same beat");

    // disabled mode never keeps the timer running
    a_disabled_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && power_mode == PM_DISABLED) |-> !timer_running)
        else $error("timer running while disabled");

    // an accepted disable shows up as disabled in the next result
    a_disable_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && command == CMD_DISABLE) |=> (out_valid && power_mode == PM_DISABLED))
        else $error("disable not reflected in result");

    // a sleep request leaves the block awake or going to sleep
    a_sleep_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sleep_request) |-> (power_mode == PM_AWAKE || power_mode == PM_GOING))
        else $error("sleep request from wrong mode");

endmodule
